### rtl/lpm_pkg.sv
// Shared types and codes for the DHCP lease pool manager.
`default_nettype none

package lpm_pkg;

    typedef enum logic [2:0] {
        CMD_DISCOVER = 3'd0,
        CMD_REQUEST  = 3'd1,
        CMD_DECLINE  = 3'd2,
        CMD_RELEASE  = 3'd3,
        CMD_INFORM   = 3'd4,
        CMD_TICK     = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        RPL_NONE  = 2'd0,
        RPL_OFFER = 2'd1,
        RPL_ACK   = 2'd2,
        RPL_NAK   = 2'd3
    } t_reply;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_PSCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [47:0] owner;
        logic [31:0] rent;
        logic [31:0] lease;
        logic        free;
    } t_entry;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_POOL_FIRST = 3'd0;
    localparam logic [2:0] REG_POOL_LAST  = 3'd1;
    localparam logic [2:0] REG_LEASE      = 3'd2;
    localparam logic [2:0] REG_HOLD       = 3'd3;
    localparam logic [2:0] REG_SERVER_ID  = 3'd4;

endpackage

`default_nettype wire

### rtl/lpm_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                    i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/dhcp_lease_pool_manager_unit.sv
// Top level of the DHCP lease pool manager: sequencer, table memories and ports.
//
// Usage: parsed DHCP messages and one-second ticks arrive as transfers on the
// s_axis channel (tuser = command, tdata = message fields). Every transfer gives
// exactly one result transfer on m_axis (tuser = reply kind, tdata = addresses
// and broadcast flag); a kind of zero means no reply is sent. Registers are
// written through the cfg channel, which is always ready; the user must write
// them while no item is open, as the block does not enforce it. Items are
// handled one at a time. Discover and a request without server id scan the
// lease table, one entry per cycle from its single read port, over the usable
// pool size (count). A request with server id searches the pending offer ring.
// Decline and release take a read-modify-write of one entry when the server id
// matches and the address lies in the pool. A tick checks min(SWEEP_PER_TICK,
// count) entries, each after a bit-serial wrap of the sweep pointer.
// After reset the whole table is cleared before s_axis is ready.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and is held at its end until the output register frees.
`default_nettype none

module dhcp_lease_pool_manager_unit #(
    parameter int POOL_DEPTH     = 256,
    parameter int PENDING_DEPTH  = 16,
    parameter int SWEEP_PER_TICK = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // stream in
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: client_mac, transaction_id, requested_ip,
    // server_id_option, client_ip, relay_ip
    input  wire  [207:0] s_axis_tdata,
    // tuser: command
    input  wire  [2:0]   s_axis_tuser,
    // stream out
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata from bit 0: your_ip, dest_ip, broadcast_flag, zero fill
    output logic [71:0]  m_axis_tdata,
    // tuser: reply_kind
    output logic [1:0]   m_axis_tuser,
    // configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data
);

    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int IW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PKW = $clog2(PENDING_DEPTH + 1);
    localparam int SWW = $clog2(SWEEP_PER_TICK + 1);
    localparam int LW  = (SWW > CW) ? SWW : CW;
    localparam int BW  = $clog2(IW + 2);
    localparam int EW  = $bits(lpm_pkg::t_entry);
    localparam int PDW = 48 + 32 + IW;

    // configuration
    logic [31:0] r_pool_first, r_pool_last, r_lease, r_hold, r_server_id;

    // sequencer
    lpm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_addr, n_addr;
    logic            r_pv, n_pv;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic [2:0]      r_cmd, n_cmd;
    logic [47:0]     r_mac, n_mac;
    logic [31:0]     r_xid, n_xid, r_req, n_req, r_ci, n_ci, r_gi, n_gi;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_tgt_off, n_tgt_off;
    logic            r_tgt_in, n_tgt_in;
    logic            r_own_f, n_own_f, r_free_f, n_free_f, r_reqfree, n_reqfree;
    logic [IW-1:0]   r_own_i, n_own_i, r_free_i, n_free_i, r_sel, n_sel;
    logic [PW-1:0]   r_paddr, n_paddr, r_pp, n_pp;
    logic [PKW-1:0]  r_pk, n_pk;
    logic            r_ppv, n_ppv;
    logic [LW-1:0]   r_left, n_left;
    logic [IW:0]     r_mv, n_mv;
    logic [CW-1:0]   r_rem, n_rem;
    logic [BW-1:0]   r_bc, n_bc;
    lpm_pkg::t_reply r_rkind, n_rkind;
    logic [31:0]     r_ryour, n_ryour, r_rdest, n_rdest;
    logic            r_rbf, n_rbf;

    // output register
    logic            r_ovld, n_ovld;
    lpm_pkg::t_reply r_okind, n_okind;
    logic [31:0]     r_oyour, n_oyour, r_odest, n_odest;
    logic            r_obf, n_obf;

    // global state
    logic [31:0]              r_now, n_now;
    logic [IW-1:0]            r_sp, n_sp;
    logic [PW-1:0]            r_head, n_head;
    logic [PENDING_DEPTH-1:0] r_pvalid, n_pvalid;

    // memories
    logic            pool_we;
    logic [IW-1:0]   pool_waddr, pool_raddr;
    logic [EW-1:0]   pool_wdata, pool_rdata;
    lpm_pkg::t_entry pool_rd, pool_wr;
    logic            pend_we;
    logic [PW-1:0]   pend_waddr, pend_raddr;
    logic [PDW-1:0]  pend_wdata, pend_rdata;
    logic [47:0]     pend_mac;
    logic [31:0]     pend_xid;
    logic [IW-1:0]   pend_idx;

    // decoded input
    logic        accept;
    logic [2:0]  in_cmd;
    logic [47:0] in_mac;
    logic [31:0] in_xid, in_req, in_sid, in_ci, in_gi;
    logic [31:0] a_diff, a_off, a_tgt;
    logic [CW-1:0] a_cnt;
    logic        a_tgt_in, a_sid_ok;

    logic scan_end, p_match, pscan_end, mod_last, out_free, blocked;

    lpm_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_pool (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rdata)
    );

    lpm_ram #(.WIDTH(PDW), .DEPTH(PENDING_DEPTH)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    assign pool_rd    = lpm_pkg::t_entry'(pool_rdata);
    assign pool_wdata = EW'(pool_wr);
    assign pend_mac   = pend_rdata[47:0];
    assign pend_xid   = pend_rdata[79:48];
    assign pend_idx   = pend_rdata[80 +: IW];

    assign s_axis_tready = (r_state == lpm_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign in_cmd = s_axis_tuser;
    assign in_mac = s_axis_tdata[47:0];
    assign in_xid = s_axis_tdata[79:48];
    assign in_req = s_axis_tdata[111:80];
    assign in_sid = s_axis_tdata[143:112];
    assign in_ci  = s_axis_tdata[175:144];
    assign in_gi  = s_axis_tdata[207:176];

    // Usable pool size: last - first + 1, clipped to the table depth, or zero if last is below first.
    assign a_diff = r_pool_last - r_pool_first;
    assign a_cnt  = (r_pool_last < r_pool_first) ? '0 :
                    (a_diff >= 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : CW'(a_diff + 32'd1);
    assign a_tgt    = (in_cmd == lpm_pkg::CMD_RELEASE) ? in_ci : in_req;
    assign a_off    = a_tgt - r_pool_first;
    assign a_tgt_in = a_off < 32'(a_cnt);
    assign a_sid_ok = (in_sid == r_server_id);

    assign scan_end  = (r_addr >= r_count) && !r_pv;
    assign p_match   = r_ppv && r_pvalid[r_pp] && (pend_mac == r_mac) && (pend_xid == r_xid);
    assign pscan_end = (r_pk == PKW'(PENDING_DEPTH)) && !r_ppv;
    assign mod_last  = (r_bc == BW'(IW));
    assign out_free  = !r_ovld || m_axis_tready;
    assign blocked   = !pool_rd.free && (pool_rd.lease == lpm_pkg::ALL_ONES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpm_pkg::ST_CLEAR: begin
                if (r_addr == CW'(POOL_DEPTH - 1)) n_state = lpm_pkg::ST_IDLE;
            end
            lpm_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        lpm_pkg::CMD_DISCOVER: n_state = lpm_pkg::ST_SCAN;
                        lpm_pkg::CMD_REQUEST: begin
                            n_state = (in_sid != 32'd0) ? lpm_pkg::ST_PSCAN
                                                        : lpm_pkg::ST_SCAN;
                        end
                        lpm_pkg::CMD_DECLINE, lpm_pkg::CMD_RELEASE: begin
                            n_state = (a_sid_ok && a_tgt_in) ? lpm_pkg::ST_RMW_RD
                                                             : lpm_pkg::ST_DONE;
                        end
                        lpm_pkg::CMD_TICK: begin
                            n_state = (a_cnt != '0) ? lpm_pkg::ST_MOD : lpm_pkg::ST_DONE;
                        end
                        default: n_state = lpm_pkg::ST_DONE;
                    endcase
                end
            end
            lpm_pkg::ST_SCAN:   if (scan_end) n_state = lpm_pkg::ST_PICK;
            lpm_pkg::ST_PICK:   n_state = lpm_pkg::ST_DONE;
            lpm_pkg::ST_PSCAN:  if (p_match || pscan_end) n_state = lpm_pkg::ST_DONE;
            lpm_pkg::ST_RMW_RD: n_state = lpm_pkg::ST_RMW_WR;
            lpm_pkg::ST_RMW_WR: begin
                n_state = (r_cmd == lpm_pkg::CMD_TICK && r_left != LW'(1))
                          ? lpm_pkg::ST_MOD : lpm_pkg::ST_DONE;
            end
            lpm_pkg::ST_MOD:    if (mod_last) n_state = lpm_pkg::ST_RMW_RD;
            lpm_pkg::ST_DONE:   if (out_free) n_state = lpm_pkg::ST_IDLE;
            default:            n_state = lpm_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [CW:0]  trial;
        logic [31:0]  ela;
        logic [IW-1:0] pick;
        logic         pick_ok;

        n_addr = r_addr;     n_pv = r_pv;         n_pidx = r_pidx;
        n_cmd = r_cmd;       n_mac = r_mac;       n_xid = r_xid;
        n_req = r_req;       n_ci = r_ci;         n_gi = r_gi;
        n_count = r_count;   n_tgt_off = r_tgt_off; n_tgt_in = r_tgt_in;
        n_own_f = r_own_f;   n_own_i = r_own_i;   n_free_f = r_free_f;
        n_free_i = r_free_i; n_reqfree = r_reqfree; n_sel = r_sel;
        n_paddr = r_paddr;   n_pp = r_pp;         n_pk = r_pk;
        n_ppv = r_ppv;       n_left = r_left;     n_mv = r_mv;
        n_rem = r_rem;       n_bc = r_bc;
        n_rkind = r_rkind;   n_ryour = r_ryour;   n_rdest = r_rdest;
        n_rbf = r_rbf;
        n_ovld = r_ovld;     n_okind = r_okind;   n_oyour = r_oyour;
        n_odest = r_odest;   n_obf = r_obf;
        n_now = r_now;       n_sp = r_sp;         n_head = r_head;
        n_pvalid = r_pvalid;

        pool_we    = 1'b0;
        pool_waddr = r_sel;
        pool_raddr = r_sel;
        pool_wr    = '{owner: r_mac, rent: r_now, lease: r_lease, free: 1'b0};
        pend_we    = 1'b0;
        pend_waddr = r_head;
        pend_raddr = r_paddr;
        pend_wdata = {r_sel, r_xid, r_mac};

        trial   = {r_rem, r_mv[IW]};
        ela     = r_now - pool_rd.rent;
        pick    = r_free_i;
        pick_ok = 1'b0;

        if (r_ovld && m_axis_tready) n_ovld = 1'b0;

        case (r_state)
            lpm_pkg::ST_CLEAR: begin
                pool_we    = 1'b1;
                pool_waddr = r_addr[IW-1:0];
                pool_wr    = '{owner: '0, rent: '0, lease: '0, free: 1'b1};
                n_addr     = r_addr + CW'(1);
            end
            lpm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd = in_cmd;  n_mac = in_mac;  n_xid = in_xid;
                    n_req = in_req;  n_ci = in_ci;    n_gi = in_gi;
                    n_count = a_cnt;
                    n_tgt_off = a_off[IW-1:0];
                    n_tgt_in  = a_tgt_in;
                    n_sel     = a_off[IW-1:0];
                    n_addr = '0;  n_pv = 1'b0;
                    n_own_f = 1'b0;  n_free_f = 1'b0;  n_reqfree = 1'b0;
                    n_paddr = r_head;  n_pk = '0;  n_ppv = 1'b0;
                    n_rkind = lpm_pkg::RPL_NONE;
                    n_ryour = '0;  n_rdest = '0;  n_rbf = 1'b0;
                    n_mv  = {1'b0, r_sp} + (IW+1)'(1);
                    n_rem = '0;  n_bc = '0;
                    n_left = (LW'(SWEEP_PER_TICK) < LW'(a_cnt)) ? LW'(SWEEP_PER_TICK)
                                                                : LW'(a_cnt);
                    if (in_cmd == lpm_pkg::CMD_TICK) n_now = r_now + 32'd1;
                    if (in_cmd == lpm_pkg::CMD_INFORM) begin
                        n_rkind = lpm_pkg::RPL_ACK;
                        n_ryour = in_ci;
                        n_rdest = in_ci;
                    end
                end
            end
            lpm_pkg::ST_SCAN: begin
                // One read issued per cycle; each entry is checked in the cycle after its read.
                pool_raddr = r_addr[IW-1:0];
                if (r_addr < r_count) begin
                    n_addr = r_addr + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_addr[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (!r_own_f && pool_rd.owner == r_mac && !blocked) begin
                        n_own_f = 1'b1;
                        n_own_i = r_pidx;
                    end
                    if (!r_free_f && pool_rd.free) begin
                        n_free_f = 1'b1;
                        n_free_i = r_pidx;
                    end
                    if (pool_rd.free && r_tgt_in && r_pidx == r_tgt_off) n_reqfree = 1'b1;
                end
            end
            lpm_pkg::ST_PICK: begin
                if (r_cmd == lpm_pkg::CMD_DISCOVER) begin
                    if (r_own_f) begin
                        pick = r_own_i;   pick_ok = 1'b1;
                    end else if (r_reqfree) begin
                        pick = r_tgt_off; pick_ok = 1'b1;
                    end else if (r_free_f) begin
                        pick = r_free_i;  pick_ok = 1'b1;
                    end
                    if (pick_ok) begin
                        pool_we    = 1'b1;
                        pool_waddr = pick;
                        pool_wr    = '{owner: r_mac, rent: r_now, lease: r_hold, free: 1'b0};
                        pend_we    = 1'b1;
                        pend_wdata = {pick, r_xid, r_mac};
                        n_pvalid[r_head] = 1'b1;
                        n_head = (r_head == PW'(PENDING_DEPTH - 1)) ? '0 : r_head + PW'(1);
                        n_rkind = lpm_pkg::RPL_OFFER;
                        n_ryour = r_pool_first + 32'(pick);
                        n_rdest = lpm_pkg::ALL_ONES;
                    end
                end else if (r_own_f) begin
                    pool_waddr = r_own_i;
                    if (r_req != 32'd0 && r_ci == 32'd0) begin
                        // Init-reboot: the requested address is checked against the pool.
                        n_rbf   = (r_gi != 32'd0);
                        n_rdest = lpm_pkg::ALL_ONES;
                        if (r_req >= r_pool_first && r_req <= r_pool_last) begin
                            pool_we = 1'b1;
                            n_rkind = lpm_pkg::RPL_ACK;
                            n_ryour = r_pool_first + 32'(r_own_i);
                        end else begin
                            n_rkind = lpm_pkg::RPL_NAK;
                        end
                    end else begin
                        pool_we = 1'b1;
                        n_rkind = lpm_pkg::RPL_ACK;
                        n_ryour = r_pool_first + 32'(r_own_i);
                        n_rdest = r_ci;
                    end
                end
            end
            lpm_pkg::ST_PSCAN: begin
                // Oldest offer first: the walk starts at the ring head.
                if (r_pk < PKW'(PENDING_DEPTH)) begin
                    n_paddr = (r_paddr == PW'(PENDING_DEPTH - 1)) ? '0 : r_paddr + PW'(1);
                    n_pk    = r_pk + PKW'(1);
                    n_ppv   = 1'b1;
                    n_pp    = r_paddr;
                end else begin
                    n_ppv = 1'b0;
                end
                if (p_match) begin
                    pool_we    = 1'b1;
                    pool_waddr = pend_idx;
                    n_pvalid[r_pp] = 1'b0;
                    n_rkind = lpm_pkg::RPL_ACK;
                    n_ryour = r_pool_first + 32'(pend_idx);
                    n_rdest = lpm_pkg::ALL_ONES;
                end
            end
            lpm_pkg::ST_RMW_RD: begin
                pool_raddr = r_sel;
            end
            lpm_pkg::ST_RMW_WR: begin
                case (r_cmd)
                    lpm_pkg::CMD_DECLINE: begin
                        pool_we = 1'b1;
                        pool_wr = '{owner: '0, rent: pool_rd.rent,
                                    lease: lpm_pkg::ALL_ONES, free: 1'b0};
                    end
                    lpm_pkg::CMD_RELEASE: begin
                        pool_we = 1'b1;
                        pool_wr = '{owner: pool_rd.owner, rent: pool_rd.rent,
                                    lease: '0, free: 1'b1};
                    end
                    lpm_pkg::CMD_TICK: begin
                        pool_we = !pool_rd.free && pool_rd.lease != lpm_pkg::ALL_ONES &&
                                  ela > pool_rd.lease;
                        pool_wr = '{owner: pool_rd.owner, rent: pool_rd.rent,
                                    lease: '0, free: 1'b1};
                        n_left = r_left - LW'(1);
                        n_mv   = {1'b0, r_sp} + (IW+1)'(1);
                        n_rem  = '0;
                        n_bc   = '0;
                    end
                    default: pool_we = 1'b0;
                endcase
            end
            lpm_pkg::ST_MOD: begin
                // Restoring remainder of (sweep pointer + 1) by count, one bit a cycle.
                if (trial >= {1'b0, r_count}) trial = trial - {1'b0, r_count};
                n_rem = trial[CW-1:0];
                n_mv  = r_mv << 1;
                n_bc  = r_bc + BW'(1);
                if (mod_last) begin
                    n_sp  = trial[IW-1:0];
                    n_sel = trial[IW-1:0];
                end
            end
            lpm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_okind = r_rkind;
                    n_oyour = r_ryour;
                    n_odest = r_rdest;
                    n_obf   = r_rbf;
                end
            end
            default: n_ovld = r_ovld;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lpm_pkg::ST_CLEAR;
            r_addr       <= '0;
            r_ovld       <= 1'b0;
            r_now        <= '0;
            r_sp         <= '0;
            r_head       <= '0;
            r_pvalid     <= '0;
            r_pool_first <= '0;
            r_pool_last  <= '0;
            r_lease      <= 32'd3600;
            r_hold       <= 32'd10;
            r_server_id  <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_ovld   <= n_ovld;
            r_now    <= n_now;
            r_sp     <= n_sp;
            r_head   <= n_head;
            r_pvalid <= n_pvalid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lpm_pkg::REG_POOL_FIRST: r_pool_first <= i_cfg_data;
                    lpm_pkg::REG_POOL_LAST:  r_pool_last  <= i_cfg_data;
                    lpm_pkg::REG_LEASE:      r_lease      <= i_cfg_data;
                    lpm_pkg::REG_HOLD:       r_hold       <= i_cfg_data;
                    lpm_pkg::REG_SERVER_ID:  r_server_id  <= i_cfg_data;
                    default:                 r_server_id  <= r_server_id;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv <= n_pv;       r_pidx <= n_pidx;   r_cmd <= n_cmd;
        r_mac <= n_mac;     r_xid <= n_xid;     r_req <= n_req;
        r_ci <= n_ci;       r_gi <= n_gi;       r_count <= n_count;
        r_tgt_off <= n_tgt_off; r_tgt_in <= n_tgt_in;
        r_own_f <= n_own_f; r_own_i <= n_own_i;
        r_free_f <= n_free_f; r_free_i <= n_free_i; r_reqfree <= n_reqfree;
        r_sel <= n_sel;     r_paddr <= n_paddr; r_pp <= n_pp;
        r_pk <= n_pk;       r_ppv <= n_ppv;     r_left <= n_left;
        r_mv <= n_mv;       r_rem <= n_rem;     r_bc <= n_bc;
        r_rkind <= n_rkind; r_ryour <= n_ryour; r_rdest <= n_rdest;
        r_rbf <= n_rbf;
        r_okind <= n_okind; r_oyour <= n_oyour; r_odest <= n_odest;
        r_obf <= n_obf;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {7'd0, r_obf, r_odest, r_oyour};

    // The table scan only reads; no entry may change under it.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lpm_pkg::ST_SCAN |-> !pool_we)
        else $error("pool written during scan");

    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lpm_pkg::ST_CLEAR |-> !s_axis_tready)
        else $error("item accepted while clearing");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpm_pkg::ST_DONE && r_ovld && !m_axis_tready)
        |=> r_state == lpm_pkg::ST_DONE)
        else $error("result overwrote a stalled output");

    a_sweep_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpm_pkg::ST_RMW_RD && r_cmd == lpm_pkg::CMD_TICK)
        |-> CW'(r_sp) < r_count)
        else $error("sweep pointer outside pool");

    a_pending_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_pvalid) <= $countones($past(r_pvalid)) + 1)
        else $error("more than one offer added at once");

endmodule

`default_nettype wire

### tb/lease_pool_checker.sv
// Checker for the lease pool manager: tracks the lease table and compares every reply.
module lease_pool_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire  [207:0] i_in_data,
    input  wire  [2:0]   i_in_user,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire  [71:0]  i_out_data,
    input  wire  [1:0]   i_out_user,
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_open_count
);

    localparam int NUM_ENTRIES = 256;
    localparam int NUM_OFFERS  = 16;
    localparam int SWEEP_STEPS = 4;

    typedef struct packed {
        lpm_pkg::t_reply kind;
        logic [31:0]     your_ip;
        logic [31:0]     dest_ip;
        logic            bcast;
    } t_reply_item;

    logic [31:0] first_addr, last_addr, lease_len, hold_len, own_id;
    logic [47:0] owner_mac [NUM_ENTRIES];
    logic [31:0] rent_at   [NUM_ENTRIES];
    logic [31:0] lease_of  [NUM_ENTRIES];
    logic        is_free   [NUM_ENTRIES];
    logic [47:0] offer_mac [NUM_OFFERS];
    logic [31:0] offer_xid [NUM_OFFERS];
    int          offer_slot[NUM_OFFERS];
    logic        offer_live[NUM_OFFERS];
    int          offer_head;
    logic [31:0] now_sec;
    int          sweep_at;
    t_reply_item replies_due[$];

    function automatic int usable_entries();
        logic [32:0] n;
        if (last_addr < first_addr) return 0;
        n = {1'b0, last_addr} - {1'b0, first_addr} + 33'd1;
        return (n > NUM_ENTRIES) ? NUM_ENTRIES : int'(n);
    endfunction

    function automatic logic blocked(int e);
        return !is_free[e] && lease_of[e] == lpm_pkg::ALL_ONES;
    endfunction

    function automatic int owned_by(logic [47:0] mac, int cnt);
        for (int e = 0; e < cnt; e++)
            if (owner_mac[e] == mac && !blocked(e)) return e;
        return -1;
    endfunction

    function automatic int entry_at(logic [31:0] addr, int cnt);
        logic [31:0] off;
        off = addr - first_addr;
        return (off < cnt) ? int'(off) : -1;
    endfunction

    task automatic grant(int e, logic [47:0] mac, logic [31:0] len);
        owner_mac[e] = mac;
        lease_of[e]  = len;
        rent_at[e]   = now_sec;
        is_free[e]   = 1'b0;
    endtask

    task automatic reset_table();
        first_addr = '0;
        last_addr  = '0;
        lease_len  = 32'd3600;
        hold_len   = 32'd10;
        own_id     = '0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            owner_mac[e] = '0;
            rent_at[e]   = '0;
            lease_of[e]  = '0;
            is_free[e]   = 1'b1;
        end
        for (int k = 0; k < NUM_OFFERS; k++) offer_live[k] = 1'b0;
        offer_head = 0;
        now_sec    = '0;
        sweep_at   = 0;
    endtask

    task automatic serve_message(logic [2:0] cmd, logic [207:0] d, output t_reply_item r);
        logic [47:0] mac;
        logic [31:0] xid, req_ip, sid_opt, ciaddr, giaddr;
        int cnt, sel, e, p;
        mac     = d[47:0];
        xid     = d[79:48];
        req_ip  = d[111:80];
        sid_opt = d[143:112];
        ciaddr  = d[175:144];
        giaddr  = d[207:176];
        cnt     = usable_entries();
        r       = '{lpm_pkg::RPL_NONE, 32'd0, 32'd0, 1'b0};
        case (cmd)
            lpm_pkg::CMD_DISCOVER: begin
                sel = owned_by(mac, cnt);
                if (sel < 0) begin
                    e = entry_at(req_ip, cnt);
                    if (e >= 0 && is_free[e]) sel = e;
                end
                if (sel < 0) begin
                    for (e = 0; e < cnt; e++)
                        if (is_free[e]) begin
                            sel = e;
                            break;
                        end
                end
                if (sel >= 0) begin
                    grant(sel, mac, hold_len);
                    offer_mac[offer_head]  = mac;
                    offer_xid[offer_head]  = xid;
                    offer_slot[offer_head] = sel;
                    offer_live[offer_head] = 1'b1;
                    offer_head = (offer_head + 1) % NUM_OFFERS;
                    r = '{lpm_pkg::RPL_OFFER, first_addr + sel, lpm_pkg::ALL_ONES, 1'b0};
                end
            end
            lpm_pkg::CMD_REQUEST: begin
                if (sid_opt != 0) begin
                    // Oldest offer first; a stale offer still commits its entry.
                    for (int k = 0; k < NUM_OFFERS; k++) begin
                        p = (offer_head + k) % NUM_OFFERS;
                        if (offer_live[p] && offer_mac[p] == mac && offer_xid[p] == xid) begin
                            grant(offer_slot[p], mac, lease_len);
                            offer_live[p] = 1'b0;
                            r = '{lpm_pkg::RPL_ACK, first_addr + offer_slot[p],
                                  lpm_pkg::ALL_ONES, 1'b0};
                            break;
                        end
                    end
                end else begin
                    sel = owned_by(mac, cnt);
                    if (sel >= 0) begin
                        if (req_ip != 0 && ciaddr == 0) begin
                            r.bcast   = (giaddr != 0);
                            r.dest_ip = lpm_pkg::ALL_ONES;
                            if (req_ip >= first_addr && req_ip <= last_addr) begin
                                grant(sel, owner_mac[sel], lease_len);
                                r.kind    = lpm_pkg::RPL_ACK;
                                r.your_ip = first_addr + sel;
                            end else begin
                                r.kind = lpm_pkg::RPL_NAK;
                            end
                        end else begin
                            grant(sel, owner_mac[sel], lease_len);
                            r = '{lpm_pkg::RPL_ACK, first_addr + sel, ciaddr, 1'b0};
                        end
                    end
                end
            end
            lpm_pkg::CMD_DECLINE: begin
                if (sid_opt == own_id) begin
                    e = entry_at(req_ip, cnt);
                    if (e >= 0) begin
                        lease_of[e]  = lpm_pkg::ALL_ONES;
                        is_free[e]   = 1'b0;
                        owner_mac[e] = '0;
                    end
                end
            end
            lpm_pkg::CMD_RELEASE: begin
                if (sid_opt == own_id) begin
                    e = entry_at(ciaddr, cnt);
                    if (e >= 0) begin
                        lease_of[e] = '0;
                        is_free[e]  = 1'b1;
                    end
                end
            end
            lpm_pkg::CMD_INFORM: r = '{lpm_pkg::RPL_ACK, ciaddr, ciaddr, 1'b0};
            lpm_pkg::CMD_TICK: begin
                now_sec = now_sec + 32'd1;
                for (int k = 0; k < ((cnt < SWEEP_STEPS) ? cnt : SWEEP_STEPS); k++) begin
                    sweep_at = (sweep_at + 1) % cnt;
                    if (!is_free[sweep_at] && lease_of[sweep_at] != lpm_pkg::ALL_ONES &&
                        (now_sec - rent_at[sweep_at]) > lease_of[sweep_at]) begin
                        is_free[sweep_at]  = 1'b1;
                        lease_of[sweep_at] = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_reply_item r, want;
        if (!i_rst_n) begin
            reset_table();
            replies_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lpm_pkg::REG_POOL_FIRST: first_addr = i_cfg_data;
                    lpm_pkg::REG_POOL_LAST:  last_addr  = i_cfg_data;
                    lpm_pkg::REG_LEASE:      lease_len  = i_cfg_data;
                    lpm_pkg::REG_HOLD:       hold_len   = i_cfg_data;
                    lpm_pkg::REG_SERVER_ID:  own_id     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                serve_message(i_in_user, i_in_data, r);
                replies_due = {replies_due, r};
            end
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply transfer with no message waiting for it");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_user != want.kind || i_out_data[31:0] != want.your_ip ||
                        i_out_data[63:32] != want.dest_ip || i_out_data[64] != want.bcast ||
                        i_out_data[71:65] != '0)
                        o_fail_count <= o_fail_count + 1;
                    if (i_out_user != want.kind)
                        $error("reply_kind: expected %0d, got %0d", want.kind, i_out_user);
                    if (i_out_data[31:0] != want.your_ip)
                        $error("your_ip: expected %h, got %h", want.your_ip, i_out_data[31:0]);
                    if (i_out_data[63:32] != want.dest_ip)
                        $error("dest_ip: expected %h, got %h", want.dest_ip, i_out_data[63:32]);
                    if (i_out_data[64] != want.bcast)
                        $error("broadcast_flag: expected %0d, got %0d", want.bcast,
                               i_out_data[64]);
                    if (i_out_data[71:65] != '0)
                        $error("zero fill: expected 0, got %h", i_out_data[71:65]);
                end
            end
        end
        o_open_count <= replies_due.size();
    end

endmodule

### tb/dhcp_lease_pool_manager_unit_tb.sv
// Stimulus and verdict for the DHCP lease pool manager.
module dhcp_lease_pool_manager_unit_tb;

    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;
    localparam int STALL_LIMIT = 6000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    int           fail_count, open_count;

    int          msgs_sent, replies_seen, quiet_cycles;
    bit          gaps_on, long_hold_req;
    int          stall_left;
    logic [31:0] cur_first, cur_sid;
    int          cur_count;
    logic [47:0] known_macs [8];
    logic [79:0] recent_offers [$];

    always #2 i_clk = ~i_clk;

    dhcp_lease_pool_manager_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    lease_pool_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_open_count(open_count)
    );

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) replies_seen <= replies_seen + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Reply side: random stalls, plus one long hold-off so the input backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) m_axis_tready <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                stall_left = 400;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 17);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_msg(logic [2:0] cmd, logic [47:0] mac, logic [31:0] xid,
                            logic [31:0] req_ip, logic [31:0] sid_opt,
                            logic [31:0] ciaddr, logic [31:0] giaddr);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {giaddr, ciaddr, sid_opt, req_ip, xid, mac};
        do @(posedge i_clk); while (!s_axis_tready);
        msgs_sent++;
        if (cmd == lpm_pkg::CMD_DISCOVER) recent_offers = {recent_offers, {xid, mac}};
        if (recent_offers.size() > 24) void'(recent_offers.pop_front());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_seen != msgs_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_pool(logic [31:0] first, logic [31:0] last, logic [31:0] lease,
                            logic [31:0] hold, logic [31:0] sid);
        logic [31:0] vals [5];
        logic [32:0] span;
        vals = '{first, last, lease, hold, sid};
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[2:0];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_first = first;
        cur_sid   = sid;
        span      = {1'b0, last} - {1'b0, first} + 33'd1;
        cur_count = (last < first) ? 0 : ((span > 256) ? 256 : int'(span));
    endtask

    function automatic logic [31:0] any_word();
        return $urandom();
    endfunction

    function automatic logic [47:0] any_mac();
        logic [63:0] w;
        w = {any_word(), any_word()};
        return w[47:0];
    endfunction

    // Mostly addresses in or just above the pool, sometimes zero or anything.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return any_word();
            1: return '0;
            default: return cur_first + $urandom_range(0, cur_count + 1);
        endcase
    endfunction

    function automatic logic [47:0] pick_mac();
        return ($urandom_range(0, 9) == 0) ? any_mac() : known_macs[$urandom_range(0, 7)];
    endfunction

    task automatic random_msg();
        logic [79:0] off;
        logic [31:0] sid, req_ip, ciaddr;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 28) begin
            send_msg(lpm_pkg::CMD_DISCOVER, pick_mac(), $urandom_range(0, 3) == 0 ? any_word()
                     : $urandom_range(0, 7), pick_addr(), '0, '0, '0);
        end else if (roll < 48) begin
            sid = ($urandom_range(0, 3) == 0) ? any_word() : cur_sid | 32'd1;
            if (recent_offers.size() != 0 && $urandom_range(0, 4) != 0) begin
                off = recent_offers[$urandom_range(0, recent_offers.size() - 1)];
                send_msg(lpm_pkg::CMD_REQUEST, off[47:0], off[79:48], pick_addr(), sid, '0,
                         any_word());
            end else begin
                send_msg(lpm_pkg::CMD_REQUEST, pick_mac(), $urandom_range(0, 7), pick_addr(),
                         sid, '0, '0);
            end
        end else if (roll < 60) begin
            // Init-reboot when ciaddr is zero and an address is asked for; else renewing.
            req_ip = ($urandom_range(0, 3) == 0) ? '0 : pick_addr();
            ciaddr = ($urandom_range(0, 1) == 0) ? '0 : pick_addr();
            send_msg(lpm_pkg::CMD_REQUEST, pick_mac(), any_word(), req_ip, '0, ciaddr,
                     $urandom_range(0, 1) ? any_word() : '0);
        end else if (roll < 64) begin
            sid = ($urandom_range(0, 4) == 0) ? any_word() : cur_sid;
            send_msg(lpm_pkg::CMD_DECLINE, pick_mac(), any_word(), pick_addr(), sid,
                     any_word(), '0);
        end else if (roll < 72) begin
            sid = ($urandom_range(0, 4) == 0) ? any_word() : cur_sid;
            send_msg(lpm_pkg::CMD_RELEASE, pick_mac(), any_word(), any_word(), sid,
                     pick_addr(), '0);
        end else if (roll < 76) begin
            send_msg(lpm_pkg::CMD_INFORM, pick_mac(), any_word(), any_word(), any_word(),
                     any_word(), any_word());
        end else if (roll < 98) begin
            send_msg(lpm_pkg::CMD_TICK, pick_mac(), any_word(), any_word(), any_word(),
                     any_word(), any_word());
        end else begin
            send_msg(roll[0] ? CMD_UNUSED_A : CMD_UNUSED_B, pick_mac(), any_word(),
                     pick_addr(), cur_sid, pick_addr(), any_word());
        end
    endtask

    initial begin
        logic [31:0] sid;
        msgs_sent    = 0;
        replies_seen = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        gaps_on      = 1'b1;
        for (int m = 0; m < 8; m++) known_macs[m] = any_mac();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: one entry at address 0, so the second client gets nothing.
        cur_first = '0;
        cur_count = 1;
        cur_sid   = '0;
        send_msg(lpm_pkg::CMD_DISCOVER, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_msg(lpm_pkg::CMD_DISCOVER, 48'h0, 32'h0, '0, '0, '0, '0);
        send_msg(lpm_pkg::CMD_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF,
                 '0, '0);
        drain();

        set_pool(32'h0A00_0010, 32'h0A00_0017, 32'd30, 32'd5, 32'h0A00_0001);
        sid = cur_sid;
        send_msg(lpm_pkg::CMD_DISCOVER, known_macs[0], 32'd11, 32'h0A00_0014, '0, '0, '0);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[0], 32'd11, '0, sid, '0, '0);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[0], 32'd12, '0, sid, '0, '0);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[0], 32'd1, 32'h0A00_0014, '0, '0,
                 32'hFFFF_FFFF);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[0], 32'd2, 32'hFFFF_FFFF, '0, '0,
                 32'h0A00_0001);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[0], 32'd3, '0, '0, 32'hFFFF_FFFF, '0);
        send_msg(lpm_pkg::CMD_REQUEST, known_macs[1], 32'd4, '0, '0, 32'h0A00_0012, '0);
        send_msg(lpm_pkg::CMD_DISCOVER, known_macs[0], 32'd5, '0, '0, '0, '0);
        send_msg(lpm_pkg::CMD_DECLINE, known_macs[2], 32'd6, 32'h0A00_0010, sid, '0, '0);
        send_msg(lpm_pkg::CMD_DECLINE, known_macs[2], 32'd6, 32'h0A00_0011, 32'hFFFF_FFFF,
                 '0, '0);
        send_msg(lpm_pkg::CMD_DISCOVER, known_macs[2], 32'd7, 32'h0A00_0010, '0, '0, '0);
        send_msg(lpm_pkg::CMD_RELEASE, known_macs[0], 32'd8, '0, sid, 32'h0A00_0014, '0);
        send_msg(lpm_pkg::CMD_RELEASE, known_macs[0], 32'd8, '0, '0, 32'h0A00_0015, '0);
        send_msg(lpm_pkg::CMD_RELEASE, known_macs[0], 32'd8, '0, sid, 32'h0A00_0010, '0);
        send_msg(lpm_pkg::CMD_INFORM, known_macs[3], 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, '0);
        send_msg(lpm_pkg::CMD_INFORM, known_macs[3], 32'd0, '0, '0, 32'h0, '0);
        for (int t = 0; t < 8; t++)
            send_msg(lpm_pkg::CMD_TICK, known_macs[4], '0, '0, '0, '0, '0);
        send_msg(CMD_UNUSED_A, known_macs[0], '0, 32'h0A00_0014, sid, '0, '0);
        send_msg(CMD_UNUSED_B, known_macs[0], '0, 32'h0A00_0014, sid, '0, '0);
        repeat (250) random_msg();
        drain();

        // Pool at the top of the address space, longest lease, no offer hold.
        set_pool(32'hFFFF_FFF8, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF);
        long_hold_req = 1'b1;
        repeat (150) random_msg();
        drain();

        // Full address space: every entry takes part, so scans are long.
        set_pool(32'h0, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'h0);
        repeat (40) random_msg();
        drain();

        // Last below first: an empty pool.
        set_pool(32'h100, 32'hFF, 32'd0, 32'hFFFF_FFFE, 32'h1234_5678);
        repeat (60) random_msg();
        drain();

        set_pool(32'hC0A8_0100, 32'hC0A8_010B, $urandom_range(1, 40), $urandom_range(0, 20),
                 32'hC0A8_0101);
        repeat (260) random_msg();
        gaps_on = 1'b0;
        repeat (120) random_msg();
        drain();
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && open_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
